/* design/prd_pkg.sv */
`default_nettype none

package prd_pkg;

  localparam int WINDOW_DEFAULT = 20;

  localparam int SAMPLE_W = 10;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 8;
  localparam int ENTRY_W  = 5;
  localparam int LEVEL_W  = 18;
  localparam int PERIOD_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT     = 3'd6;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 10'd520;
  localparam logic [SAMPLE_W-1:0] GATE_LOW_RST   = 10'd500;
  localparam logic [SAMPLE_W-1:0] GATE_HIGH_RST  = 10'd550;
  localparam logic [PERIOD_W-1:0] REFRACTORY_RST = 16'd300;
  localparam logic [RATE_W-1:0]   MIN_RATE_RST   = 8'd30;
  localparam logic [RATE_W-1:0]   MAX_RATE_RST   = 8'd220;
  localparam logic [PERIOD_W-1:0] REPORT_RST     = 16'd1000;

  localparam logic [LEVEL_W-1:0] LEVEL_RST = 18'd133120;

  // new level = (256*sample + 4*old + 2) / 5, divide by 5 as multiply and shift
  localparam int FILT_X_W     = 21;
  localparam int FILT_RECIP_W = 22;
  localparam int FILT_PROD_W  = FILT_X_W + FILT_RECIP_W;
  localparam int FILT_SHIFT   = 24;
  localparam logic [FILT_RECIP_W-1:0] FILT_RECIP = 22'd3355444;

  localparam int DIVIDEND_W = 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam logic [DIVIDEND_W-1:0] RATE_NUMERATOR = 16'd60000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] pulse_threshold;
    logic [SAMPLE_W-1:0] gate_low;
    logic [SAMPLE_W-1:0] gate_high;
    logic [PERIOD_W-1:0] refractory_ms;
    logic [RATE_W-1:0]   min_rate;
    logic [RATE_W-1:0]   max_rate;
    logic [PERIOD_W-1:0] report_period_ms;
  } prd_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
    logic                in_gate;
  } prd_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [TIME_W-1:0]     divisor;
  } prd_div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT_MUL,
    ST_FILT_SET,
    ST_PULSE,
    ST_DIV_RATE,
    ST_RATE_CHK,
    ST_RING_WR,
    ST_REPORT,
    ST_DIV_AVG,
    ST_OUT
  } prd_state_t;

endpackage

`default_nettype wire

/* design/prd_front.sv */
`default_nettype none

module prd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire prd_pkg::prd_cfg_t             cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [prd_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [prd_pkg::TIME_W-1:0]    now_ms,
  output logic                               push_valid,
  output prd_pkg::prd_item_t                 push_item,
  input  wire logic                          push_ready
);

  logic               vld_q;
  logic               vld_next;
  logic               accept;
  logic               push;
  prd_pkg::prd_item_t item_q;

  assign push     = vld_q && push_ready;
  assign in_stall = vld_q && !push_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_next = vld_q;
    if (accept) begin
      vld_next = 1'b1;
    end else if (push) begin
      vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_next;
    end
  end

  // classify against the gate window on entry
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.sample  <= sample;
      item_q.now_ms  <= now_ms;
      item_q.in_gate <= (sample >= cfg.gate_low) && (sample <= cfg.gate_high);
    end
  end

  assign push_valid = vld_q;
  assign push_item  = item_q;

endmodule

`default_nettype wire

/* design/prd_fifo.sv */
`default_nettype none

module prd_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  input  wire prd_pkg::prd_item_t push_item,
  output logic                    push_ready,
  output logic                    head_valid,
  output prd_pkg::prd_item_t      head_item,
  input  wire logic               pop
);

  prd_pkg::prd_item_t                  mem_q [prd_pkg::QUEUE_DEPTH];
  logic [prd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q;
  logic [prd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q;
  logic [prd_pkg::QUEUE_CNT_W-1:0]     cnt_q;
  logic                                do_push;
  logic                                do_pop;

  assign push_ready = cnt_q != prd_pkg::QUEUE_CNT_W'(prd_pkg::QUEUE_DEPTH);
  assign head_valid = cnt_q != '0;
  assign head_item  = mem_q[rd_ptr_q];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* design/prd_div.sv */
`default_nettype none

module prd_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire prd_pkg::prd_div_req_t           req,
  output logic                                 done,
  output logic [prd_pkg::DIVIDEND_W-1:0]       quotient
);

  logic                                busy_q;
  logic                                done_q;
  logic [prd_pkg::DIV_CNT_W-1:0]       cnt_q;
  logic [prd_pkg::TIME_W-1:0]          rem_q;
  logic [prd_pkg::TIME_W-1:0]          dvs_q;
  logic [prd_pkg::DIVIDEND_W-1:0]      quo_q;
  logic [prd_pkg::TIME_W:0]            trial;
  logic                                fits;
  logic                                last;

  assign trial = {rem_q, quo_q[prd_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign last  = cnt_q == prd_pkg::DIV_CNT_W'(prd_pkg::DIVIDEND_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_q <= '0;
      dvs_q <= req.divisor;
      quo_q <= req.dividend;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= prd_pkg::TIME_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[prd_pkg::TIME_W-1:0];
      end
      quo_q <= {quo_q[prd_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign done     = done_q;
  assign quotient = quo_q;

endmodule

`default_nettype wire

/* design/prd_back.sv */
`default_nettype none

module prd_back #(
  parameter int WINDOW = prd_pkg::WINDOW_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire prd_pkg::prd_cfg_t                 cfg,
  input  wire logic                              head_valid,
  input  wire prd_pkg::prd_item_t                head_item,
  output logic                                   pop,
  output prd_pkg::prd_div_req_t                  div_req,
  input  wire logic                              div_done,
  input  wire logic [prd_pkg::DIVIDEND_W-1:0]    div_quo,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [prd_pkg::RATE_W-1:0]             average_rate,
  output logic [prd_pkg::ENTRY_W-1:0]            entries_used
);

  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = prd_pkg::RATE_W + CNT_W;

  prd_pkg::prd_state_t state_q;
  prd_pkg::prd_state_t state_next;

  logic                                  ld_item;
  logic                                  filt_mul;
  logic                                  filt_set;
  logic                                  pulse_upd;
  logic                                  ring_wr;
  logic                                  rep_upd;
  logic                                  out_load;
  logic                                  start_rate;
  logic                                  start_avg;

  prd_pkg::prd_item_t                    item_q;
  logic [prd_pkg::LEVEL_W-1:0]           level_q;
  logic [prd_pkg::FILT_PROD_W-1:0]       prod_q;
  logic [prd_pkg::FILT_X_W-1:0]          filt_x;
  logic [prd_pkg::TIME_W-1:0]            last_pulse_q;
  logic [prd_pkg::TIME_W-1:0]            last_rep_q;
  logic [prd_pkg::TIME_W-1:0]            interval;
  logic [prd_pkg::TIME_W-1:0]            elapsed;
  logic [prd_pkg::RATE_W-1:0]            rate_q;
  logic                                  pulse_hit;
  logic                                  rate_ok;
  logic                                  report_due;

  logic [prd_pkg::RATE_W-1:0]            ring_mem [WINDOW];
  logic [WINDOW-1:0]                     ring_vld_q;
  logic [prd_pkg::RATE_W-1:0]            rd_data_q;
  logic                                  rd_vld_q;
  logic [POS_W-1:0]                      pos_q;
  logic [SUM_W-1:0]                      sum_q;
  logic [SUM_W-1:0]                      sum_next;
  logic [CNT_W-1:0]                      cnt_q;
  logic [CNT_W-1:0]                      cnt_next;
  logic [7:0]                            cnt_ext;

  logic                                  out_vld_q;
  logic [prd_pkg::RATE_W-1:0]            avg_q;
  logic [prd_pkg::ENTRY_W-1:0]           ent_q;

  assign interval   = item_q.now_ms - last_pulse_q;
  assign elapsed    = item_q.now_ms - last_rep_q;
  assign pulse_hit  = (level_q > {cfg.pulse_threshold, 8'h00})
                      && (interval > prd_pkg::TIME_W'(cfg.refractory_ms));
  assign rate_ok    = (div_quo > prd_pkg::DIVIDEND_W'(cfg.min_rate))
                      && (div_quo < prd_pkg::DIVIDEND_W'(cfg.max_rate));
  assign report_due = (elapsed > prd_pkg::TIME_W'(cfg.report_period_ms)) && (cnt_q != '0);

  always_comb begin
    state_next = state_q;
    unique case (state_q)
      prd_pkg::ST_IDLE: begin
        if (head_valid) begin
          state_next = head_item.in_gate ? prd_pkg::ST_FILT_MUL : prd_pkg::ST_REPORT;
        end
      end
      prd_pkg::ST_FILT_MUL: state_next = prd_pkg::ST_FILT_SET;
      prd_pkg::ST_FILT_SET: state_next = prd_pkg::ST_PULSE;
      prd_pkg::ST_PULSE: begin
        state_next = pulse_hit ? prd_pkg::ST_DIV_RATE : prd_pkg::ST_REPORT;
      end
      prd_pkg::ST_DIV_RATE: begin
        if (div_done) begin
          state_next = prd_pkg::ST_RATE_CHK;
        end
      end
      prd_pkg::ST_RATE_CHK: begin
        state_next = rate_ok ? prd_pkg::ST_RING_WR : prd_pkg::ST_REPORT;
      end
      prd_pkg::ST_RING_WR: state_next = prd_pkg::ST_REPORT;
      prd_pkg::ST_REPORT: begin
        state_next = report_due ? prd_pkg::ST_DIV_AVG : prd_pkg::ST_IDLE;
      end
      prd_pkg::ST_DIV_AVG: begin
        if (div_done) begin
          state_next = prd_pkg::ST_OUT;
        end
      end
      prd_pkg::ST_OUT: begin
        if (!out_vld_q || !out_stall) begin
          state_next = prd_pkg::ST_IDLE;
        end
      end
      default: state_next = prd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ld_item    = 1'b0;
    filt_mul   = 1'b0;
    filt_set   = 1'b0;
    pulse_upd  = 1'b0;
    ring_wr    = 1'b0;
    rep_upd    = 1'b0;
    out_load   = 1'b0;
    start_rate = 1'b0;
    start_avg  = 1'b0;
    unique case (state_q)
      prd_pkg::ST_IDLE:     ld_item    = head_valid;
      prd_pkg::ST_FILT_MUL: filt_mul   = 1'b1;
      prd_pkg::ST_FILT_SET: filt_set   = 1'b1;
      prd_pkg::ST_PULSE:    start_rate = pulse_hit;
      prd_pkg::ST_DIV_RATE: ;
      prd_pkg::ST_RATE_CHK: pulse_upd  = 1'b1;
      prd_pkg::ST_RING_WR:  ring_wr    = 1'b1;
      prd_pkg::ST_REPORT: begin
        rep_upd   = report_due;
        start_avg = report_due;
      end
      prd_pkg::ST_DIV_AVG:  ;
      prd_pkg::ST_OUT:      out_load   = !out_vld_q || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = start_rate || start_avg;
    div_req.dividend = start_avg ? prd_pkg::DIVIDEND_W'(sum_q) : prd_pkg::RATE_NUMERATOR;
    div_req.divisor  = start_avg ? prd_pkg::TIME_W'(cnt_q) : interval;
  end

  assign pop = ld_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= prd_pkg::ST_IDLE;
    end else begin
      state_q <= state_next;
    end
  end

  assign filt_x = prd_pkg::FILT_X_W'({item_q.sample, 8'h00})
                  + prd_pkg::FILT_X_W'({level_q, 2'b00})
                  + prd_pkg::FILT_X_W'(2);

  always_ff @(posedge clk) begin
    if (ld_item) begin
      item_q <= head_item;
    end
    if (filt_mul) begin
      prod_q <= prd_pkg::FILT_PROD_W'(filt_x) * prd_pkg::FILT_PROD_W'(prd_pkg::FILT_RECIP);
    end
    if (pulse_upd) begin
      rate_q <= div_quo[prd_pkg::RATE_W-1:0];
    end
  end

  assign sum_next = sum_q - SUM_W'(rd_vld_q ? rd_data_q : '0) + SUM_W'(rate_q);
  assign cnt_next = cnt_q - CNT_W'(rd_vld_q) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      level_q      <= prd_pkg::LEVEL_RST;
      last_pulse_q <= '0;
      last_rep_q   <= '0;
      pos_q        <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      ring_vld_q   <= '0;
    end else begin
      if (filt_set) begin
        level_q <= prod_q[prd_pkg::FILT_SHIFT +: prd_pkg::LEVEL_W];
      end
      if (pulse_upd) begin
        last_pulse_q <= item_q.now_ms;
      end
      if (rep_upd) begin
        last_rep_q <= item_q.now_ms;
      end
      if (ring_wr) begin
        sum_q             <= sum_next;
        cnt_q             <= cnt_next;
        ring_vld_q[pos_q] <= 1'b1;
        pos_q             <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_wr) begin
      ring_mem[pos_q] <= rate_q;
    end
    rd_data_q <= ring_mem[pos_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ring_vld_q[pos_q] && !ring_wr;
    end
  end

  assign cnt_ext = 8'(cnt_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_q <= div_quo[prd_pkg::RATE_W-1:0];
      ent_q <= cnt_ext[prd_pkg::ENTRY_W-1:0];
    end
  end

  assign out_valid    = out_vld_q;
  assign average_rate = avg_q;
  assign entries_used = ent_q;

endmodule

`default_nettype wire

/* design/pulse_rate_detector.sv */
`default_nettype none

// channel  direction  handshake               payload
// in       to block   in_valid / in_stall     sample[9:0], now_ms[31:0]
// out      from block out_valid / out_stall   average_rate[7:0], entries_used[4:0]
// cfg      to block   cfg_valid / cfg_ready   cfg_index[2:0], cfg_data[15:0]
//
// The back end takes an item outside the gate through IDLE and REPORT, and an item
// inside it with no pulse and no report through IDLE, FILT_MUL, FILT_SET, PULSE
// and REPORT. Each rate or average division holds it on the one shared restoring
// divider until done, which bounds how fast items go through the back end.
// The front stage and a two-entry queue take items while the back end works.
// rst is synchronous; the ring is empty right after reset, no clearing pass.
// A stalled result holds in the output register; the back end waits only when
// a second result is ready, and the input stalls once queue and front are full.

module pulse_rate_detector #(
  parameter int WINDOW = prd_pkg::WINDOW_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [prd_pkg::SAMPLE_W-1:0]      sample,
  input  wire logic [prd_pkg::TIME_W-1:0]        now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [prd_pkg::RATE_W-1:0]             average_rate,
  output logic [prd_pkg::ENTRY_W-1:0]            entries_used,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [prd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [prd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  prd_pkg::prd_cfg_t                   cfg_q;
  logic                                push_valid;
  prd_pkg::prd_item_t                  push_item;
  logic                                push_ready;
  logic                                head_valid;
  prd_pkg::prd_item_t                  head_item;
  logic                                pop;
  prd_pkg::prd_div_req_t               div_req;
  logic                                div_done;
  logic [prd_pkg::DIVIDEND_W-1:0]      div_quo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.pulse_threshold  <= prd_pkg::THRESHOLD_RST;
      cfg_q.gate_low         <= prd_pkg::GATE_LOW_RST;
      cfg_q.gate_high        <= prd_pkg::GATE_HIGH_RST;
      cfg_q.refractory_ms    <= prd_pkg::REFRACTORY_RST;
      cfg_q.min_rate         <= prd_pkg::MIN_RATE_RST;
      cfg_q.max_rate         <= prd_pkg::MAX_RATE_RST;
      cfg_q.report_period_ms <= prd_pkg::REPORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prd_pkg::REG_THRESHOLD:  cfg_q.pulse_threshold  <= cfg_data[prd_pkg::SAMPLE_W-1:0];
        prd_pkg::REG_GATE_LOW:   cfg_q.gate_low         <= cfg_data[prd_pkg::SAMPLE_W-1:0];
        prd_pkg::REG_GATE_HIGH:  cfg_q.gate_high        <= cfg_data[prd_pkg::SAMPLE_W-1:0];
        prd_pkg::REG_REFRACTORY: cfg_q.refractory_ms    <= cfg_data;
        prd_pkg::REG_MIN_RATE:   cfg_q.min_rate         <= cfg_data[prd_pkg::RATE_W-1:0];
        prd_pkg::REG_MAX_RATE:   cfg_q.max_rate         <= cfg_data[prd_pkg::RATE_W-1:0];
        prd_pkg::REG_REPORT:     cfg_q.report_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  prd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_q),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .now_ms     (now_ms),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  prd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  prd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  prd_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_q),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .div_req      (div_req),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average_rate (average_rate),
    .entries_used (entries_used)
  );

endmodule

`default_nettype wire
